@@ design/dst_pkg.sv @@
// shared types, constants and constant-divisor helpers for the digit step tuner
`timescale 1ns / 1ps

package dst_pkg;

  // register map, word index on the configuration port
  localparam int unsigned AddrWidth = 4;
  typedef enum logic [1:0] {
    REG_BLANK_CODE = 2'd0,
    REG_BRIGHT_MIN = 2'd1,
    REG_BRIGHT_MAX = 2'd2
  } reg_index_t;

  // reset values of the registers
  localparam logic [3:0] BLANK_CODE_RESET = 4'd15;
  localparam logic [7:0] BRIGHT_MIN_RESET = 8'd1;
  localparam logic [7:0] BRIGHT_MAX_RESET = 8'd15;

  // button codes, the remaining code is ignored
  typedef enum logic [2:0] {
    BTN_NONE       = 3'd0,
    BTN_ONES_UP    = 3'd1,
    BTN_ONES_DOWN  = 3'd2,
    BTN_TENS_UP    = 3'd3,
    BTN_TENS_DOWN  = 3'd4,
    BTN_HUND_UP    = 3'd5,
    BTN_HUND_DOWN  = 3'd6
  } button_t;

  // band limits in half-kHz units
  localparam logic [12:0] BAND_LOW   = 13'd300;
  localparam logic [12:0] BAND_HIGH  = 13'd3500;
  localparam logic [12:0] BAND_EXTRA = 13'd4364;

  // one accepted input transaction
  typedef struct packed {
    logic [2:0]  button;
    logic        fine_mode;
    logic [12:0] stored_freq;
    logic [12:0] display_freq;
    logic        self_test_active;
    logic        half_second_tick;
  } item_t;

  // configuration register set
  typedef struct packed {
    logic [3:0] blank_code;
    logic [7:0] bright_min;
    logic [7:0] bright_max;
  } cfg_t;

  // tuner results for one transaction
  typedef struct packed {
    logic [12:0] current_freq;
    logic [7:0]  brightness;
    logic        brightness_changed;
  } tune_res_t;

  // five display digits, thousands digit first
  typedef struct packed {
    logic [3:0] thousands;
    logic [3:0] hundreds;
    logic [3:0] tens;
    logic [3:0] units;
    logic [3:0] half;
  } digits_t;

  // x / 10 for a 12-bit value, reciprocal 6554 / 2^16 is exact over the range
  function automatic logic [8:0] div10(input logic [11:0] x);
    logic [24:0] p;
    p = 25'(x) * 25'd6554;
    return p[24:16];
  endfunction

  // x / 100 for a 12-bit value, reciprocal 5243 / 2^19
  function automatic logic [5:0] div100(input logic [11:0] x);
    logic [24:0] p;
    p = 25'(x) * 25'd5243;
    return p[24:19];
  endfunction

  // x / 1000 for a 12-bit value, reciprocal 4195 / 2^22
  function automatic logic [2:0] div1000(input logic [11:0] x);
    logic [24:0] p;
    p = 25'(x) * 25'd4195;
    return p[24:22];
  endfunction

endpackage

@@ design/digit_step_tuner_with_display_top.sv @@
// top level: configuration registers, input register, result register
`timescale 1ns / 1ps

// Takes one button transaction per clock cycle while the output side is not
// stalling, and returns one result for each. A transaction is held in the input
// register, where the tuner step, the brightness step and the five-digit split
// of the display frequency are all worked out combinationally, and its result
// is loaded into the output register once that register is free. The digit
// split uses constant reciprocals between the two registers. Configuration is
// to be written over the APB-style port at word addresses 0 (blank code),
// 1 (lowest brightness) and 2 (highest brightness) only while no transaction
// is in flight; the block itself does not enforce this.
module digit_step_tuner_with_display_top import dst_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  // configuration port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  // input channel
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [2:0]           button,
  input  logic                 fine_mode,
  input  logic [12:0]          stored_freq,
  input  logic [12:0]          display_freq,
  input  logic                 self_test_active,
  input  logic                 half_second_tick,
  // output channel
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [12:0]          current_freq,
  output logic [3:0]           digit_half,
  output logic [3:0]           digit_units,
  output logic [3:0]           digit_tens,
  output logic [3:0]           digit_hundreds,
  output logic [3:0]           digit_thousands,
  output logic [7:0]           brightness,
  output logic                 brightness_changed
);

  cfg_t      cfg;
  logic      cfg_wr;
  logic      s1_valid;
  item_t     s1_item;
  logic      s1_advance;
  logic      upd;
  tune_res_t tune_res;
  digits_t   digits;

  // register writes
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.blank_code <= BLANK_CODE_RESET;
      cfg.bright_min <= BRIGHT_MIN_RESET;
      cfg.bright_max <= BRIGHT_MAX_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_BLANK_CODE: cfg.blank_code <= pwdata[3:0];
        REG_BRIGHT_MIN: cfg.bright_min <= pwdata[7:0];
        REG_BRIGHT_MAX: cfg.bright_max <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    unique case (paddr[3:2])
      REG_BLANK_CODE: prdata = {28'd0, cfg.blank_code};
      REG_BRIGHT_MIN: prdata = {24'd0, cfg.bright_min};
      REG_BRIGHT_MAX: prdata = {24'd0, cfg.bright_max};
      default:        prdata = '0;
    endcase
  end

  // flow control between input and result registers
  assign s1_advance = !out_valid || out_ready;
  assign in_ready   = !s1_valid || s1_advance;
  assign upd        = s1_valid && s1_advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item.button           <= button;
      s1_item.fine_mode        <= fine_mode;
      s1_item.stored_freq      <= stored_freq;
      s1_item.display_freq     <= display_freq;
      s1_item.self_test_active <= self_test_active;
      s1_item.half_second_tick <= half_second_tick;
    end
  end

  // tuner and display logic
  dst_tuner u_tuner (
    .clk  (clk),
    .rst  (rst),
    .upd  (upd),
    .item (s1_item),
    .cfg  (cfg),
    .res  (tune_res)
  );

  dst_display u_display (
    .clk    (clk),
    .rst    (rst),
    .upd    (upd),
    .item   (s1_item),
    .cfg    (cfg),
    .digits (digits)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      current_freq       <= tune_res.current_freq;
      brightness         <= tune_res.brightness;
      brightness_changed <= tune_res.brightness_changed;
      digit_half         <= digits.half;
      digit_units        <= digits.units;
      digit_tens         <= digits.tens;
      digit_hundreds     <= digits.hundreds;
      digit_thousands    <= digits.thousands;
    end
  end

  // both registers full and the output stalled: no new transaction may enter
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_valid && !out_ready |-> !in_ready)
    else $error("input taken while both registers are full");

  // a held transaction moves to the output as soon as the result register frees
  a_s1_moves: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_advance |=> out_valid)
    else $error("transaction lost between input and result registers");

endmodule

@@ design/dst_tuner.sv @@
// fine digit stepping of the kept frequency and brightness stepping in channel mode
`timescale 1ns / 1ps

module dst_tuner import dst_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      upd,
  input  item_t     item,
  input  cfg_t      cfg,
  output tune_res_t res
);

  logic [11:0] tuned_freq;
  logic [11:0] tuned_freq_next;
  logic [7:0]  bright_level;
  logic [7:0]  bright_level_next;

  logic [11:0] half_f;
  logic [8:0]  q10;
  logic [5:0]  q100;
  logic [4:0]  mod20;
  logic [3:0]  tens;
  logic [4:0]  hund;
  logic [11:0] stepped;
  logic [7:0]  lvl_dn;
  logic [7:0]  lvl_up;

  // digit fields of the kept frequency
  always_comb begin
    half_f = {1'b0, tuned_freq[11:1]};
    q10    = div10(half_f);
    q100   = div100(half_f);
    mod20  = 5'(tuned_freq - 12'(q10) * 12'd20);
    tens   = 4'(q10 - 9'(q100) * 9'd10);
    hund   = (q100 == 6'd20) ? 5'd0 : q100[4:0];
  end

  // one digit step with wrap inside its range
  always_comb begin
    stepped = tuned_freq;
    case (item.button)
      BTN_ONES_UP:   stepped = (mod20 == 5'd19) ? tuned_freq - 12'd19 : tuned_freq + 12'd1;
      BTN_ONES_DOWN: stepped = (mod20 == 5'd0) ? tuned_freq + 12'd19 : tuned_freq - 12'd1;
      BTN_TENS_UP:   stepped = (tens == 4'd9) ? tuned_freq - 12'd180 : tuned_freq + 12'd20;
      BTN_TENS_DOWN: stepped = (tens == 4'd0) ? tuned_freq + 12'd180 : tuned_freq - 12'd20;
      BTN_HUND_UP:   stepped = (hund == 5'd19) ? tuned_freq - 12'd3800 : tuned_freq + 12'd200;
      BTN_HUND_DOWN: stepped = (hund == 5'd0) ? tuned_freq + 12'd3800 : tuned_freq - 12'd200;
      default:       stepped = tuned_freq;
    endcase
  end

  // brightness one step down or up, then clamped to the limits
  always_comb begin
    lvl_dn = (bright_level == 8'd0) ? 8'd0 : bright_level - 8'd1;
    if (lvl_dn < cfg.bright_min) begin
      lvl_dn = cfg.bright_min;
    end
    lvl_up = (bright_level == 8'hff) ? 8'hff : bright_level + 8'd1;
    if (lvl_up > cfg.bright_max) begin
      lvl_up = cfg.bright_max;
    end
  end

  // next state for this transaction
  always_comb begin
    tuned_freq_next   = tuned_freq;
    bright_level_next = bright_level;
    if (item.fine_mode) begin
      tuned_freq_next = stepped;
    end else if (item.button == BTN_TENS_UP) begin
      bright_level_next = lvl_dn;
    end else if (item.button == BTN_TENS_DOWN) begin
      bright_level_next = lvl_up;
    end
  end

  // results
  always_comb begin
    res.current_freq       = item.fine_mode ? {1'b0, tuned_freq_next} : item.stored_freq;
    res.brightness         = bright_level_next;
    res.brightness_changed = (bright_level_next != bright_level);
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tuned_freq   <= '0;
      bright_level <= BRIGHT_MIN_RESET;
    end else if (upd) begin
      tuned_freq   <= tuned_freq_next;
      bright_level <= bright_level_next;
    end
  end

  // channel transactions never move the kept frequency
  a_freq_hold: assert property (@(posedge clk) disable iff (rst)
    !(upd && item.fine_mode) |=> $stable(tuned_freq))
    else $error("kept frequency moved outside a fine-mode transaction");

  // fine transactions never move the brightness
  a_level_hold: assert property (@(posedge clk) disable iff (rst)
    !(upd && !item.fine_mode) |=> $stable(bright_level))
    else $error("brightness moved outside a channel-mode transaction");

endmodule

@@ design/dst_display.sv @@
// five-digit split of the display frequency, leading-zero blanking and blink control
`timescale 1ns / 1ps

module dst_display import dst_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    upd,
  input  item_t   item,
  input  cfg_t    cfg,
  output digits_t digits
);

  logic        blink_phase;
  logic        blink_phase_next;
  logic [11:0] half_v;
  logic [8:0]  q1;
  logic [5:0]  q2;
  logic [2:0]  q3;
  logic        steady;
  digits_t     raw;

  // decimal split by constant reciprocals
  always_comb begin
    half_v = item.display_freq[12:1];
    q1     = div10(half_v);
    q2     = div100(half_v);
    q3     = div1000(half_v);
    raw.half      = item.display_freq[0] ? 4'd5 : 4'd0;
    raw.units     = 4'(half_v - 12'(q1) * 12'd10);
    raw.tens      = 4'(q1 - 9'(q2) * 9'd10);
    raw.hundreds  = 4'(q2 - 6'(q3) * 6'd10);
    raw.thousands = {1'b0, q3};
  end

  // band check and blink phase
  always_comb begin
    steady = ((item.display_freq >= BAND_LOW && item.display_freq <= BAND_HIGH) ||
              item.display_freq == BAND_EXTRA) && !item.self_test_active;
    blink_phase_next = blink_phase;
    if (!steady && item.half_second_tick) begin
      blink_phase_next = ~blink_phase;
    end
  end

  // leading-zero blanking, then blanking of the whole row in the off phase
  always_comb begin
    digits = raw;
    if (raw.thousands == 4'd0) begin
      digits.thousands = cfg.blank_code;
      if (raw.hundreds == 4'd0) begin
        digits.hundreds = cfg.blank_code;
        if (raw.tens == 4'd0) begin
          digits.tens = cfg.blank_code;
        end
      end
    end
    if (!steady && blink_phase) begin
      digits = {5{cfg.blank_code}};
    end
  end

  // blink phase register
  always_ff @(posedge clk) begin
    if (rst) begin
      blink_phase <= 1'b0;
    end else if (upd) begin
      blink_phase <= blink_phase_next;
    end
  end

  // the phase only turns on a tick
  a_blink_tick: assert property (@(posedge clk) disable iff (rst)
    !(upd && item.half_second_tick) |=> $stable(blink_phase))
    else $error("blink phase toggled without a tick");

endmodule

@@ tb/tb_digit_step_tuner_with_display_top.sv @@
// self-checking testbench for the digit step tuner with five-digit display
`timescale 1ns / 1ps

module tb_digit_step_tuner_with_display_top;
  import dst_pkg::*;

  localparam int CycleLimit  = 400000;
  localparam int SettleCycles = 8;

  // one expected readout: tuner side and display side
  typedef struct packed {
    tune_res_t tune;
    digits_t   dig;
  } readout_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                 psel    = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite  = 1'b0;
  logic [AddrWidth-1:0] paddr   = '0;
  logic [31:0]          pwdata  = '0;
  logic [31:0]          prdata;
  logic                 pready;

  logic  in_valid  = 1'b0;
  logic  in_ready;
  item_t drv_item  = '0;
  logic  out_valid;
  logic  out_ready = 1'b0;

  logic [12:0] current_freq;
  logic [3:0]  digit_half;
  logic [3:0]  digit_units;
  logic [3:0]  digit_tens;
  logic [3:0]  digit_hundreds;
  logic [3:0]  digit_thousands;
  logic [7:0]  brightness;
  logic        brightness_changed;

  // shadow copy of the block state and registers
  cfg_t        cfg_shadow;
  logic [11:0] tuned_freq;
  logic        blink_phase;
  logic [7:0]  bright_level;

  item_t    button_events[$];
  readout_t expected_readouts[$];

  logic in_taken  = 1'b0;
  logic out_taken = 1'b0;
  int   gap_left  = 0;
  int   gap_run   = 0;
  int   stall_left = 0;
  int   stall_run  = 0;
  int   btn_run   = 0;
  int   btn_pick  = 0;
  int   mode_pick = 0;
  int   errors    = 0;
  int   cycle_count = 0;

  digit_step_tuner_with_display_top i_dut (
    .clk                (clk),
    .rst                (rst),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .button             (drv_item.button),
    .fine_mode          (drv_item.fine_mode),
    .stored_freq        (drv_item.stored_freq),
    .display_freq       (drv_item.display_freq),
    .self_test_active   (drv_item.self_test_active),
    .half_second_tick   (drv_item.half_second_tick),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .current_freq       (current_freq),
    .digit_half         (digit_half),
    .digit_units        (digit_units),
    .digit_tens         (digit_tens),
    .digit_hundreds     (digit_hundreds),
    .digit_thousands    (digit_thousands),
    .brightness         (brightness),
    .brightness_changed (brightness_changed)
  );

  // clock
  always #2 clk = ~clk;

  // idle length per transaction, with occasional stretches of back-to-back traffic
  function automatic int draw_wait(inout int run_left);
    if (run_left > 0) begin
      run_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      run_left = $urandom_range(20, 60);
      return 0;
    end
    return $urandom_range(0, 19);
  endfunction

  // step the tuner or brightness and split the display frequency
  function automatic void predict_readout(input item_t it, output readout_t r);
    int f;
    int tens_d;
    int hund_d;
    int lvl;
    int hv;
    int d0, d1, d2, d3, d4;
    logic [7:0] old_level;
    bit steady;
    old_level = bright_level;
    if (it.fine_mode) begin
      f = tuned_freq;
      tens_d = ((f >> 1) / 10) % 10;
      hund_d = ((f >> 1) / 100) % 20;
      case (it.button)
        BTN_ONES_UP:   f = (f % 20 == 19) ? f - 19 : f + 1;
        BTN_ONES_DOWN: f = (f % 20 == 0) ? f + 19 : f - 1;
        BTN_TENS_UP:   f = (tens_d == 9) ? f - 180 : f + 20;
        BTN_TENS_DOWN: f = (tens_d == 0) ? f + 180 : f - 20;
        BTN_HUND_UP:   f = (hund_d == 19) ? f - 3800 : f + 200;
        BTN_HUND_DOWN: f = (hund_d == 0) ? f + 3800 : f - 200;
        default: ;
      endcase
      tuned_freq = 12'(f);
      r.tune.current_freq = {1'b0, tuned_freq};
    end else begin
      // tens up dims, tens down brightens
      if (it.button == BTN_TENS_UP) begin
        lvl = (bright_level == 0) ? 0 : int'(bright_level) - 1;
        if (lvl < int'(cfg_shadow.bright_min)) lvl = cfg_shadow.bright_min;
        bright_level = 8'(lvl);
      end else if (it.button == BTN_TENS_DOWN) begin
        lvl = (bright_level == 8'd255) ? 255 : int'(bright_level) + 1;
        if (lvl > int'(cfg_shadow.bright_max)) lvl = cfg_shadow.bright_max;
        bright_level = 8'(lvl);
      end
      r.tune.current_freq = it.stored_freq;
    end
    r.tune.brightness = bright_level;
    r.tune.brightness_changed = (bright_level != old_level);

    // digit split with leading zero blanking
    hv = it.display_freq >> 1;
    d0 = it.display_freq[0] ? 5 : 0;
    d1 = hv % 10;
    d2 = (hv / 10) % 10;
    d3 = (hv / 100) % 10;
    d4 = (hv / 1000) % 10;
    if (d4 == 0) begin
      d4 = cfg_shadow.blank_code;
      if (d3 == 0) begin
        d3 = cfg_shadow.blank_code;
        if (d2 == 0) d2 = cfg_shadow.blank_code;
      end
    end

    // blinking outside the band or during the self test
    steady = ((it.display_freq >= BAND_LOW && it.display_freq <= BAND_HIGH) ||
              it.display_freq == BAND_EXTRA) && !it.self_test_active;
    if (!steady) begin
      if (blink_phase) begin
        d0 = cfg_shadow.blank_code;
        d1 = cfg_shadow.blank_code;
        d2 = cfg_shadow.blank_code;
        d3 = cfg_shadow.blank_code;
        d4 = cfg_shadow.blank_code;
        if (it.half_second_tick) blink_phase = 1'b0;
      end else if (it.half_second_tick) begin
        blink_phase = 1'b1;
      end
    end
    r.dig.half      = 4'(d0);
    r.dig.units     = 4'(d1);
    r.dig.tens      = 4'(d2);
    r.dig.hundreds  = 4'(d3);
    r.dig.thousands = 4'(d4);
  endfunction

  function automatic item_t mk_event(input logic [2:0] btn, input logic fine,
                                     input int stored, input int disp,
                                     input logic test, input logic tick);
    item_t it;
    it.button = btn;
    it.fine_mode = fine;
    it.stored_freq = 13'(stored);
    it.display_freq = 13'(disp);
    it.self_test_active = test;
    it.half_second_tick = tick;
    return it;
  endfunction

  // mostly runs of one button in one mode, with some noise
  function automatic item_t random_event();
    item_t it;
    int sel;
    if (btn_run == 0) begin
      btn_run = $urandom_range(1, 24);
      btn_pick = $urandom_range(0, 7);
      mode_pick = $urandom_range(0, 1);
    end
    btn_run--;
    it.button = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7)) : 3'(btn_pick);
    it.fine_mode = ($urandom_range(0, 9) == 0) ? !mode_pick[0] : mode_pick[0];
    it.stored_freq = 13'($urandom_range(0, 8191));
    sel = $urandom_range(0, 9);
    if (sel < 4) begin
      it.display_freq = 13'($urandom_range(300, 3500));
    end else if (sel == 4) begin
      it.display_freq = BAND_EXTRA;
    end else if (sel == 5) begin
      case ($urandom_range(0, 7))
        0: it.display_freq = 13'd0;
        1: it.display_freq = 13'd299;
        2: it.display_freq = 13'd300;
        3: it.display_freq = 13'd3500;
        4: it.display_freq = 13'd3501;
        5: it.display_freq = 13'd4363;
        6: it.display_freq = 13'd4365;
        default: it.display_freq = 13'd8191;
      endcase
    end else begin
      it.display_freq = 13'($urandom_range(0, 8191));
    end
    it.self_test_active = ($urandom_range(0, 7) == 0);
    it.half_second_tick = ($urandom_range(0, 2) == 0);
    return it;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t %s mismatch: expected %0d actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  // input driver, one transaction at a time from the event queue
  always @(negedge clk) begin
    if (!rst) begin
      if (in_valid && !in_taken) begin
        // hold until accepted
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (button_events.size() > 0) begin
        drv_item <= button_events.pop_front();
        in_valid <= 1'b1;
        gap_left = draw_wait(gap_run);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output back-pressure
  always @(negedge clk) begin
    if (out_taken) stall_left = draw_wait(stall_run);
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // monitor: predict on input transactions, compare on output transactions
  always @(posedge clk) begin : mon
    readout_t want;
    in_taken  <= in_valid && in_ready;
    out_taken <= out_valid && out_ready;
    if (!rst && in_valid && in_ready) begin
      predict_readout(drv_item, want);
      expected_readouts.push_back(want);
    end
    if (!rst && out_valid && out_ready) begin
      if (expected_readouts.size() == 0) begin
        $display("%0t unexpected result: expected none actual current_freq %0d",
                 $time, current_freq);
        errors++;
      end else begin
        want = expected_readouts.pop_front();
        check_field("current_freq", want.tune.current_freq, current_freq);
        check_field("digit_half", want.dig.half, digit_half);
        check_field("digit_units", want.dig.units, digit_units);
        check_field("digit_tens", want.dig.tens, digit_tens);
        check_field("digit_hundreds", want.dig.hundreds, digit_hundreds);
        check_field("digit_thousands", want.dig.thousands, digit_thousands);
        check_field("brightness", want.tune.brightness, brightness);
        check_field("brightness_changed", want.tune.brightness_changed,
                    brightness_changed);
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("FAIL digit_step_tuner_with_display_top");
      $finish;
    end
  end

  // register write, setup then access phase
  task automatic reg_write(input reg_index_t idx, input logic [7:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= AddrWidth'(4 * int'(idx));
    pwdata <= 32'(value);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_BLANK_CODE: cfg_shadow.blank_code = value[3:0];
      REG_BRIGHT_MIN: cfg_shadow.bright_min = value;
      REG_BRIGHT_MAX: cfg_shadow.bright_max = value;
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_config(input logic [3:0] blank, input logic [7:0] lo,
                            input logic [7:0] hi);
    reg_write(REG_BLANK_CODE, {4'd0, blank});
    reg_write(REG_BRIGHT_MIN, lo);
    reg_write(REG_BRIGHT_MAX, hi);
  endtask

  // sender holds off until every result is back, then a short settle
  // checked on the rising edge, away from the driver's falling-edge updates
  task automatic drain_and_settle();
    while (!(button_events.size() == 0 && !in_valid && expected_readouts.size() == 0))
      @(posedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic push_random(input int count);
    repeat (count) button_events.push_back(random_event());
  endtask

  // stimulus and verdict
  initial begin
    cfg_shadow = '{blank_code: BLANK_CODE_RESET, bright_min: BRIGHT_MIN_RESET,
                   bright_max: BRIGHT_MAX_RESET};
    tuned_freq = '0;
    blink_phase = 1'b0;
    bright_level = BRIGHT_MIN_RESET;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: digit wraps, ignored codes, band edges, blinking, brightness
    button_events.push_back(mk_event(BTN_ONES_DOWN, 1'b1, 0, 0, 1'b0, 1'b0));
    button_events.push_back(mk_event(BTN_ONES_UP, 1'b1, 8191, 8191, 1'b0, 1'b1));
    button_events.push_back(mk_event(BTN_TENS_DOWN, 1'b1, 0, 299, 1'b0, 1'b0));
    button_events.push_back(mk_event(BTN_TENS_UP, 1'b1, 0, 300, 1'b0, 1'b1));
    button_events.push_back(mk_event(BTN_HUND_DOWN, 1'b1, 0, 3500, 1'b0, 1'b0));
    button_events.push_back(mk_event(BTN_HUND_UP, 1'b1, 0, 3501, 1'b0, 1'b1));
    button_events.push_back(mk_event(BTN_HUND_UP, 1'b1, 0, 4364, 1'b0, 1'b0));
    button_events.push_back(mk_event(BTN_NONE, 1'b1, 0, 4363, 1'b0, 1'b0));
    button_events.push_back(mk_event(3'd7, 1'b1, 0, 4365, 1'b0, 1'b0));
    button_events.push_back(mk_event(BTN_HUND_DOWN, 1'b1, 0, 1, 1'b1, 1'b1));
    button_events.push_back(mk_event(BTN_ONES_DOWN, 1'b1, 0, 2000, 1'b1, 1'b0));
    button_events.push_back(mk_event(BTN_TENS_UP, 1'b0, 0, 20, 1'b0, 1'b1));
    button_events.push_back(mk_event(BTN_TENS_DOWN, 1'b0, 8191, 2000, 1'b0, 1'b0));
    button_events.push_back(mk_event(BTN_TENS_DOWN, 1'b0, 4096, 1234, 1'b0, 1'b0));
    button_events.push_back(mk_event(BTN_ONES_UP, 1'b0, 300, 200, 1'b0, 1'b0));
    button_events.push_back(mk_event(BTN_HUND_DOWN, 1'b0, 1, 4364, 1'b0, 1'b0));
    button_events.push_back(mk_event(3'd7, 1'b0, 5, 8190, 1'b0, 1'b0));
    button_events.push_back(mk_event(BTN_TENS_UP, 1'b0, 7, 3000, 1'b0, 1'b0));
    drain_and_settle();

    // full brightness range, zero blank code
    set_config(4'd0, 8'd0, 8'd255);
    push_random(210);
    drain_and_settle();

    // top of the range
    set_config(4'd15, 8'd250, 8'd255);
    push_random(210);
    drain_and_settle();

    // crossed limits
    set_config(4'd9, 8'd200, 8'd10);
    push_random(210);
    drain_and_settle();

    // bottom of the range
    set_config(4'd0, 8'd0, 8'd0);
    push_random(210);
    drain_and_settle();

    // arbitrary setting
    set_config(4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
               8'($urandom_range(0, 255)));
    push_random(210);
    drain_and_settle();

    if (expected_readouts.size() != 0) begin
      $display("%0t results missing: expected %0d actual 0", $time,
               expected_readouts.size());
      errors++;
    end
    if (errors == 0) begin
      $display("PASS digit_step_tuner_with_display_top");
    end else begin
      $display("FAIL digit_step_tuner_with_display_top");
    end
    $finish;
  end

endmodule
